// ===== rtl/ffta_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit timed unit allocator: shared definitions
// Sizes, reset values and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package ffta_pkg;

   localparam int MAX_UNITS = 128;

   localparam int TIME_W = 20;
   localparam int NEED_W = 8;
   localparam int DUR_W  = 10;
   localparam int BUSY_W = 21;
   localparam int SUM_W  = 14;
   localparam int NUM_W  = 8;

   localparam int IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
   localparam int CNT_W = $clog2(MAX_UNITS + 1);
   localparam int CMP_W = (CNT_W > NUM_W) ? CNT_W : NUM_W;

   localparam logic [NUM_W-1:0] NUM_UNITS_RESET = NUM_W'(128);

   typedef struct packed {
      logic load;      // capture a request and clear the accumulators
      logic scan;      // walk the unit table, one entry per cycle
      logic alloc;     // while scanning: take free units instead of counting
      logic restart;   // rewind the walk for the next pass
      logic load_rsp;  // place the result in the output register
   } ffta_cmd_type;

   typedef struct packed {
      logic pass_done;  // every unit in use has been read and judged
      logic enough;     // free units cover the request
      logic rsp_room;   // output register can take a result this cycle
   } ffta_sts_type;

endpackage

// ===== rtl/first_fit_timed_unit_allocator_top.sv =====
// ----------------------------------------------------------------------------
// First-fit timed unit allocator
// Top level: controller, datapath and the port wiring.
// ----------------------------------------------------------------------------
// Each request is handled on its own. The busy-until table (csr_num_units
// units in use, capped at 128) has a single read port, so it is walked once to
// count free units and, for a granted request, once more to take the
// lowest-numbered ones. Each walk reads the units in use in turn, judges the
// last unit and then leaves the walk. The next request is taken as soon as the
// result sits in the output register, even while that result still waits for
// its transfer. A result that is still held by rsp_stall when the next one is
// ready keeps the block, and with it the input, waiting until it is taken.
// No clearing pass is needed after reset.
module first_fit_timed_unit_allocator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ffta_pkg::TIME_W-1:0] req_task_time,
   input  logic [ffta_pkg::NEED_W-1:0] req_units_needed,
   input  logic [ffta_pkg::DUR_W-1:0]  req_duration,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_granted,
   output logic [ffta_pkg::SUM_W-1:0]  rsp_unit_id_sum,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ffta_pkg::NUM_W-1:0]  csr_num_units
);
   import ffta_pkg::*;

   ffta_cmd_type cmd;
   ffta_sts_type sts;

   // The user must send register writes only while idle; the block does not enforce it, and all are taken.
   assign csr_ready = 1'b1;

   ffta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ffta_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_task_time    (req_task_time),
      .req_units_needed (req_units_needed),
      .req_duration     (req_duration),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_num_units    (csr_num_units),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_unit_id_sum  (rsp_unit_id_sum)
   );

endmodule

// ===== rtl/ffta_dpath.sv =====
// ----------------------------------------------------------------------------
// First-fit timed unit allocator: datapath
// Busy-until table with per-unit valid bits, the request registers, the scan
// pipeline that counts or takes free units, and the result register.
// ----------------------------------------------------------------------------
module ffta_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  ffta_pkg::ffta_cmd_type          cmd,
   output ffta_pkg::ffta_sts_type          sts,
   input  logic [ffta_pkg::TIME_W-1:0]     req_task_time,
   input  logic [ffta_pkg::NEED_W-1:0]     req_units_needed,
   input  logic [ffta_pkg::DUR_W-1:0]      req_duration,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [ffta_pkg::NUM_W-1:0]      csr_num_units,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_granted,
   output logic [ffta_pkg::SUM_W-1:0]      rsp_unit_id_sum
);
   import ffta_pkg::*;

   logic [BUSY_W-1:0] busy_mem [MAX_UNITS];
   logic [MAX_UNITS-1:0] written_ff;

   logic [NUM_W-1:0]  num_units_ff;
   logic [TIME_W-1:0] now_ff;
   logic [NEED_W-1:0] need_ff;
   logic [DUR_W-1:0]  dur_ff;
   logic [CNT_W-1:0]  count_ff;

   logic [CNT_W-1:0]  issue_ff;
   logic              pend_ff;
   logic [IDX_W-1:0]  pidx_ff;
   logic [BUSY_W-1:0] rd_busy_ff;
   logic              rd_written_ff;

   logic [CNT_W-1:0]  free_cnt_ff;
   logic [CNT_W-1:0]  taken_ff;
   logic [SUM_W-1:0]  sum_ff;

   logic              rsp_valid_ff;
   logic              rsp_granted_ff;
   logic [SUM_W-1:0]  rsp_sum_ff;

   logic [CNT_W-1:0]  count_in;
   logic [IDX_W-1:0]  issue_idx;
   logic              issue_more;
   logic              unit_free;
   logic              take_unit;
   logic [BUSY_W-1:0] busy_new;

   // Unit count in use, held to the table depth.
   always_comb begin
      if (CMP_W'(num_units_ff) > CMP_W'(MAX_UNITS)) begin
         count_in = CNT_W'(MAX_UNITS);
      end else begin
         count_in = CNT_W'(num_units_ff);
      end
   end

   assign issue_idx  = issue_ff[IDX_W-1:0];
   assign issue_more = (issue_ff < count_ff);
   // A unit that was never written counts as free, whatever its table entry holds.
   assign unit_free  = !rd_written_ff || (rd_busy_ff <= BUSY_W'(now_ff));
   assign take_unit  = cmd.scan && cmd.alloc && pend_ff && unit_free &&
                       (CMP_W'(taken_ff) < CMP_W'(need_ff));
   assign busy_new   = BUSY_W'(now_ff) + BUSY_W'(dur_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_units_ff <= NUM_UNITS_RESET;
      end else if (csr_valid && csr_ready) begin
         num_units_ff <= csr_num_units;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff   <= req_task_time;
         need_ff  <= req_units_needed;
         dur_ff   <= req_duration;
         count_ff <= count_in;
      end
   end

   // Table read and write ports: one read and one write per cycle.
   always_ff @(posedge clock) begin
      rd_busy_ff <= busy_mem[issue_idx];
      if (take_unit) begin
         busy_mem[pidx_ff] <= busy_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (take_unit) begin
         written_ff[pidx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff      <= '0;
         pend_ff       <= 1'b0;
         pidx_ff       <= '0;
         rd_written_ff <= 1'b0;
         free_cnt_ff   <= '0;
         taken_ff      <= '0;
         sum_ff        <= '0;
      end else if (cmd.load) begin
         issue_ff    <= '0;
         pend_ff     <= 1'b0;
         free_cnt_ff <= '0;
         taken_ff    <= '0;
         sum_ff      <= '0;
      end else if (cmd.restart) begin
         issue_ff <= '0;
         pend_ff  <= 1'b0;
      end else if (cmd.scan) begin
         rd_written_ff <= written_ff[issue_idx];
         pidx_ff       <= issue_idx;
         pend_ff       <= issue_more;
         if (issue_more) begin
            issue_ff <= issue_ff + CNT_W'(1);
         end
         if (!cmd.alloc && pend_ff && unit_free) begin
            free_cnt_ff <= free_cnt_ff + CNT_W'(1);
         end
         if (take_unit) begin
            taken_ff <= taken_ff + CNT_W'(1);
            sum_ff   <= sum_ff + SUM_W'(pidx_ff) + SUM_W'(1);
         end
      end
   end

   assign sts.pass_done = !issue_more && !pend_ff;
   assign sts.enough    = (CMP_W'(free_cnt_ff) >= CMP_W'(need_ff));
   assign sts.rsp_room  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_granted_ff <= sts.enough;
         rsp_sum_ff     <= sts.enough ? sum_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_unit_id_sum = rsp_sum_ff;

endmodule

// ===== rtl/ffta_ctrl.sv =====
// ----------------------------------------------------------------------------
// First-fit timed unit allocator: controller
// Sequences one request through a counting pass, the grant decision, an
// allocation pass when granted, and the hand-off to the output register.
// ----------------------------------------------------------------------------
module ffta_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output ffta_pkg::ffta_cmd_type cmd,
   input  ffta_pkg::ffta_sts_type sts
);
   import ffta_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COUNT,
      S_DECIDE,
      S_ALLOC,
      S_RESULT
   } state_type;

   state_type state_ff;
   logic      stall_ff;
   logic      accept;

   assign accept = req_valid && !stall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_COUNT;
                  stall_ff <= 1'b1;
               end
            end
            S_COUNT: begin
               if (sts.pass_done) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               state_ff <= sts.enough ? S_ALLOC : S_RESULT;
            end
            S_ALLOC: begin
               if (sts.pass_done) begin
                  state_ff <= S_RESULT;
               end
            end
            S_RESULT: begin
               if (sts.rsp_room) begin
                  state_ff <= S_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == S_IDLE) && accept;
      cmd.scan     = (state_ff == S_COUNT) || (state_ff == S_ALLOC);
      cmd.alloc    = (state_ff == S_ALLOC);
      cmd.restart  = (state_ff == S_DECIDE);
      cmd.load_rsp = (state_ff == S_RESULT) && sts.rsp_room;
   end

   assign req_stall = stall_ff;

endmodule

// ===== tb/first_fit_timed_unit_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// First-fit timed unit allocator: self-checking testbench
// A directed table opens the run, with some results written out and the rest
// left to the allocation model. Random requests follow over a series of
// unit-count settings. Each result is checked in order against the written-out value or the model.
// ----------------------------------------------------------------------------
module first_fit_timed_unit_allocator_top_tb;
   import ffta_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 400;
   localparam int NUM_PHASES   = 12;
   localparam int NUM_DIRECTED = 21;
   localparam int DRAIN_CYCLES = 2 * MAX_UNITS + 20;
   localparam int TIME_MAX     = (1 << TIME_W) - 1;
   localparam int FINAL_STAMP  = 1040000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic             granted;
      logic [SUM_W-1:0] unit_id_sum;
   } grant_type;

   typedef struct packed {
      logic [TIME_W-1:0] task_time;
      logic [NEED_W-1:0] units_needed;
      logic [DUR_W-1:0]  duration;
      logic              typed;
      grant_type         result;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [TIME_W-1:0]   req_task_time;
   logic [NEED_W-1:0]   req_units_needed;
   logic [DUR_W-1:0]    req_duration;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_granted;
   logic [SUM_W-1:0]    rsp_unit_id_sum;
   logic                csr_valid;
   logic                csr_ready;
   logic [NUM_W-1:0]    csr_num_units;

   // Allocation model state.
   logic [BUSY_W-1:0]   unit_busy_until [MAX_UNITS];
   logic [NUM_W-1:0]    units_cfg;
   grant_type           expected_grants [$];

   int                  stamp;
   int                  sender_idle_pct = 0;
   int                  rsp_stall_pct = 0;
   int                  hold_requests = 0;
   int                  requests_sent = 0;
   int                  granted_count = 0;
   int                  refused_count = 0;
   int                  csr_writes = 0;
   int                  mismatches = 0;

   int unsigned phase_units [NUM_PHASES] =
      '{128, 0, 1, 5, 255, 16, 85, 3, 40, 170, 8, 128};
   int unsigned phase_items [NUM_PHASES] =
      '{80, 30, 80, 200, 60, 250, 80, 200, 200, 40, 150, 70};
   idle_mode_type phase_modes [NUM_PHASES] =
      '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_NONE, IDLE_BOTH, IDLE_SENDER,
        IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

   // Rows run from reset with all 128 units in use.
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{20'd1,    8'd1,   10'd1,    1'b1, '{1'b1, 14'd1}},
      '{20'd1,    8'd0,   10'd1023, 1'b1, '{1'b1, 14'd0}},
      '{20'd2,    8'd255, 10'd1023, 1'b1, '{1'b0, 14'd0}},
      '{20'd2,    8'd128, 10'd1023, 1'b1, '{1'b1, 14'd8256}},
      '{20'd3,    8'd1,   10'd5,    1'b1, '{1'b0, 14'd0}},
      '{20'd1025, 8'd1,   10'd1,    1'b1, '{1'b1, 14'd1}},
      '{20'd1025, 8'd127, 10'd512,  1'b0, '{1'b0, 14'd0}},
      '{20'd500,  8'd1,   10'd10,   1'b1, '{1'b0, 14'd0}},
      '{20'd0,    8'd0,   10'd0,    1'b1, '{1'b1, 14'd0}},
      '{20'd1026, 8'd1,   10'd0,    1'b0, '{1'b0, 14'd0}},
      '{20'd1026, 8'd1,   10'd0,    1'b0, '{1'b0, 14'd0}},
      '{20'd1600, 8'd85,  10'd341,  1'b0, '{1'b0, 14'd0}},
      '{20'd1601, 8'd170, 10'd682,  1'b0, '{1'b0, 14'd0}},
      '{20'd1602, 8'd43,  10'd1023, 1'b0, '{1'b0, 14'd0}},
      '{20'd1603, 8'd1,   10'd1,    1'b0, '{1'b0, 14'd0}},
      '{20'd3000, 8'd64,  10'd100,  1'b0, '{1'b0, 14'd0}},
      '{20'd3001, 8'd100, 10'd1,    1'b0, '{1'b0, 14'd0}},
      '{20'd3001, 8'd64,  10'd1,    1'b0, '{1'b0, 14'd0}},
      '{20'd3002, 8'd127, 10'd1023, 1'b0, '{1'b0, 14'd0}},
      '{20'd3100, 8'd128, 10'd1023, 1'b0, '{1'b0, 14'd0}},
      '{20'd4123, 8'd3,   10'd10,   1'b0, '{1'b0, 14'd0}}
   };

   first_fit_timed_unit_allocator_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_task_time    (req_task_time),
      .req_units_needed (req_units_needed),
      .req_duration     (req_duration),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_unit_id_sum  (rsp_unit_id_sum),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_num_units    (csr_num_units)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int units_active();
      return (units_cfg > MAX_UNITS) ? MAX_UNITS : int'(units_cfg);
   endfunction

   // Counts free units first; only when enough are free does it take the
   // lowest-numbered ones and push their busy-until time out.
   function automatic grant_type predict_allocation(input logic [TIME_W-1:0] t,
                                                    input logic [NEED_W-1:0] need,
                                                    input logic [DUR_W-1:0]  dur);
      int        active;
      int        free_cnt;
      int        taken;
      grant_type res;
      active   = units_active();
      free_cnt = 0;
      taken    = 0;
      res      = '0;
      for (int i = 0; i < active; i++) begin
         if (unit_busy_until[i] <= {1'b0, t}) free_cnt++;
      end
      if (free_cnt < int'(need)) return res;
      for (int i = 0; i < active && taken < int'(need); i++) begin
         if (unit_busy_until[i] <= {1'b0, t}) begin
            unit_busy_until[i] = {1'b0, t} + BUSY_W'(dur);
            res.unit_id_sum    = res.unit_id_sum + SUM_W'(i + 1);
            taken++;
         end
      end
      res.granted = 1'b1;
      return res;
   endfunction

   task automatic send_request(input logic [TIME_W-1:0] t, input logic [NEED_W-1:0] need,
                               input logic [DUR_W-1:0] dur, input logic typed,
                               input grant_type typed_result);
      grant_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_task_time    <= t;
      req_units_needed <= need;
      req_duration     <= dur;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // The model always advances, even where the expected value is written out.
      predicted = predict_allocation(t, need, dur);
      expected_grants.push_back(typed ? typed_result : predicted);
      requests_sent++;
   endtask

   task automatic write_num_units(input logic [NUM_W-1:0] value);
      csr_valid     <= 1'b1;
      csr_num_units <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      units_cfg = value;
      csr_writes++;
   endtask

   task automatic wait_for_drain(input int pause_cycles);
      req_valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (pause_cycles) @(posedge clock);
   endtask

   // Result side: checks each transfer and drives the stall pattern.
   initial begin
      int        hold_left;
      int        holds_served;
      grant_type got;
      grant_type want;
      hold_left    = 0;
      holds_served = 0;
      rsp_stall    = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '{rsp_granted, rsp_unit_id_sum};
            if (expected_grants.size() == 0) begin
               $display("%0t: unexpected result granted=%0d unit_id_sum=%0d",
                        $time, got.granted, got.unit_id_sum);
               mismatches++;
            end else begin
               want = expected_grants.pop_front();
               if (got.granted !== want.granted) begin
                  $display("%0t: granted mismatch, expected %0d actual %0d",
                           $time, want.granted, got.granted);
                  mismatches++;
               end
               if (got.unit_id_sum !== want.unit_id_sum) begin
                  $display("%0t: unit_id_sum mismatch, expected %0d actual %0d",
                           $time, want.unit_id_sum, got.unit_id_sum);
                  mismatches++;
               end
            end
            if (got.granted) granted_count++;
            else refused_count++;
         end
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int r;
      int active;
      logic [NEED_W-1:0] need;
      logic [DUR_W-1:0]  dur;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_task_time    = '0;
      req_units_needed = '0;
      req_duration     = '0;
      csr_valid        = 1'b0;
      csr_num_units    = NUM_UNITS_RESET;
      units_cfg        = NUM_UNITS_RESET;
      for (int i = 0; i < MAX_UNITS; i++) unit_busy_until[i] = '0;
      stamp = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            wait_for_drain(4);
            write_num_units(NUM_W'(phase_units[ph]));
         end
         sender_idle_pct = (phase_modes[ph] == IDLE_SENDER) ? 45 :
                           (phase_modes[ph] == IDLE_BOTH) ? 23 : 0;
         rsp_stall_pct <= (phase_modes[ph] == IDLE_RECEIVER) ? 45 :
                          (phase_modes[ph] == IDLE_BOTH) ? 23 : 0;

         if (ph == 0) begin
            foreach (directed_rows[k])
               send_request(directed_rows[k].task_time, directed_rows[k].units_needed,
                            directed_rows[k].duration, directed_rows[k].typed,
                            directed_rows[k].result);
            stamp = directed_rows[NUM_DIRECTED-1].task_time;
         end
         // With few units the block fills quickly while results are held back.
         if (phase_units[ph] == 5) hold_requests <= hold_requests + 1;
         // The last setting runs up to the top of the time range.
         if (ph == NUM_PHASES - 1 && stamp < FINAL_STAMP) stamp = FINAL_STAMP;

         for (int k = 0; k < int'(phase_items[ph]); k++) begin
            active = units_active();
            r = $urandom_range(99);
            if (r < 2 && stamp > 50) stamp = stamp - $urandom_range(1, 50);
            else if (r < 5) stamp = stamp + $urandom_range(1000, 30000);
            else stamp = stamp + $urandom_range(0, 24);
            if (stamp > TIME_MAX) stamp = TIME_MAX;

            r = $urandom_range(99);
            if (r < 3) dur = '0;
            else if (r < 15) dur = DUR_W'($urandom_range(0, 1023));
            else dur = DUR_W'($urandom_range(1, 200));

            r = $urandom_range(99);
            if (r < 5) need = '0;
            else if (r < 10) need = NEED_W'($urandom_range(0, 255));
            else if (r < 25) need = NEED_W'($urandom_range(0, active));
            else need = NEED_W'($urandom_range(1, (active / 4 > 1) ? active / 4 : 1));

            send_request(TIME_W'(stamp), need, dur, 1'b0, '0);
         end
      end

      wait_for_drain(DRAIN_CYCLES);
      $display("Covered %0d requests (%0d directed) over %0d unit-count settings.",
               requests_sent, NUM_DIRECTED, csr_writes + 1);
      $display("Results: %0d granted, %0d refused, %0d mismatches.",
               granted_count, refused_count, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
